// File: hdl/wildcard_byte_pattern_scan_unit_assert.svh
// ----------------------------------------------------------------------------
// wildcard byte pattern scan unit assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_UNIT_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WBPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("wbps assertion failed");

// next-cycle implication
`define WBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("wbps assertion failed");

`else

`define WBPS_ASSERT_SAME(label, ante, cons)
`define WBPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hdl/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// shared constants, register codes and types of the pattern scan unit
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_SIG_BYTES = 16;
    localparam int SIG_W         = 8 * MAX_SIG_BYTES;
    localparam int SIG_IDX_W     = $clog2(MAX_SIG_BYTES);
    localparam int LEN_W         = 5;
    localparam int CNT_W         = 32;
    localparam int ADDR_W        = 64;
    localparam int OFS_W         = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [7:0] WILDCARD_BYTE = 8'hCC;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS     = 3'd0,
        REG_ADDED_OFFSET     = 3'd1,
        REG_SIGNATURE_LOW    = 3'd2,
        REG_SIGNATURE_HIGH   = 3'd3,
        REG_SIGNATURE_LENGTH = 3'd4
    } t_cfg_reg;

    // one decided result, from the matcher to the result stage
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [CNT_W-1:0] start;
    } t_hit;

    // address terms used by the result stage
    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [OFS_W-1:0]  added_offset;
    } t_addr_cfg;

endpackage

// File: hdl/wbps_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps channel interfaces
// valid/ready channels for input bytes, results and register writes
// ----------------------------------------------------------------------------
interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

interface wbps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/wildcard_byte_pattern_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_unit
// searches a byte stream for a signature of up to 16 bytes with 0xCC wildcards
// ----------------------------------------------------------------------------
// The region is streamed one byte per beat on i_in, in address order, with
// last_byte set on its final byte. After each byte, once at least
// signature_length bytes of the region have arrived, the newest bytes are
// compared in parallel against the signature; a signature byte of 0xCC matches
// anything. The first match gives one beat on o_out with found = 1 and
// match_address = base_address + match start + added_offset (mod 2^64); the
// rest of the region then gives nothing. A region that ends unmatched gives
// found = 0 with address 0. A byte is taken every cycle unless stalled: the
// compare is one combinational pass from the window registers to a holding
// register, and the address add happens on the way into the output register.
// The input stalls only when both the holding stage and the output register
// are full and o_out is stalled. Registers are written over i_cfg (index 0
// base, 1 offset, 2 signature bytes 0..7, 3 bytes 8..15, 4 length) only while
// the unit is idle, as the user must ensure; the unit does not enforce it.
// i_cfg never stalls. A length of 0 acts as 1 and one above 16 acts as 16.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wbps_in_if.sink     i_in,
    wbps_out_if.source  o_out,
    wbps_cfg_if.sink    i_cfg
);
    import wbps_pkg::*;

    // configuration registers
    logic [ADDR_W-1:0]     r_base_address;
    logic [OFS_W-1:0]      r_added_offset;
    logic [SIG_W/2-1:0]    r_signature_low;
    logic [SIG_W/2-1:0]    r_signature_high;
    logic [LEN_W-1:0]      r_signature_length;

    logic                  in_ready;
    logic                  in_accept;
    t_hit                  hit;
    t_addr_cfg             addr_cfg;

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address     <= '0;
            r_added_offset     <= '0;
            r_signature_low    <= '0;
            r_signature_high   <= '0;
            r_signature_length <= LEN_W'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_BASE_ADDRESS:     r_base_address     <= i_cfg.data;
                REG_ADDED_OFFSET:     r_added_offset     <= i_cfg.data[OFS_W-1:0];
                REG_SIGNATURE_LOW:    r_signature_low    <= i_cfg.data;
                REG_SIGNATURE_HIGH:   r_signature_high   <= i_cfg.data;
                REG_SIGNATURE_LENGTH: r_signature_length <= i_cfg.data[LEN_W-1:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // a byte beat is taken when the result side has room for whatever it decides
    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid && in_ready;

    // window compare and region bookkeeping
    wbps_match u_match (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_accept),
        .i_data_byte        (i_in.data_byte),
        .i_last_byte        (i_in.last_byte),
        .i_signature        ({r_signature_high, r_signature_low}),
        .i_signature_length (r_signature_length),
        .o_hit              (hit)
    );

    assign addr_cfg.base_address = r_base_address;
    assign addr_cfg.added_offset = r_added_offset;

    // holding stage, address add and output register
    wbps_result u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hit      (hit),
        .i_addr_cfg (addr_cfg),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );

endmodule

// File: hdl/wbps_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_match
// byte window, region byte count and parallel wildcard compare
// ----------------------------------------------------------------------------
module wbps_match (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    input  logic [wbps_pkg::SIG_W-1:0]     i_signature,
    input  logic [wbps_pkg::LEN_W-1:0]     i_signature_length,
    output wbps_pkg::t_hit                 o_hit
);
    import wbps_pkg::*;

    // previous bytes, index 0 is the one before the newest
    logic [7:0]       r_window [MAX_SIG_BYTES-1];
    logic [CNT_W-1:0] r_seen;
    logic             r_reported;

    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] n_seen;
    logic [7:0]       age_byte [MAX_SIG_BYTES];
    logic [MAX_SIG_BYTES-1:0] pos_ok;
    logic             window_hit;
    logic             match;

    always_comb begin
        if (i_signature_length == '0) begin
            len = LEN_W'(1);
        end else if (i_signature_length > LEN_W'(MAX_SIG_BYTES)) begin
            len = LEN_W'(MAX_SIG_BYTES);
        end else begin
            len = i_signature_length;
        end
    end

    assign n_seen = (r_seen == '1) ? r_seen : r_seen + CNT_W'(1);

    // byte of age k is compared with signature byte len-1-k
    always_comb begin
        logic [LEN_W-1:0] sidx;
        logic [7:0]       sbyte;
        for (int k = 0; k < MAX_SIG_BYTES; k++) begin
            age_byte[k] = (k == 0) ? i_data_byte : r_window[(k == 0) ? 0 : k - 1];
            sidx        = len - LEN_W'(1) - LEN_W'(k);
            sbyte       = i_signature[8 * sidx[SIG_IDX_W-1:0] +: 8];
            pos_ok[k]   = (LEN_W'(k) >= len) || (sbyte == WILDCARD_BYTE)
                          || (sbyte == age_byte[k]);
        end
    end

    assign window_hit = &pos_ok;
    assign match      = window_hit && (n_seen >= CNT_W'(len));

    always_comb begin
        o_hit.valid = i_accept && !r_reported && (match || i_last_byte);
        o_hit.found = match;
        o_hit.start = n_seen - CNT_W'(len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
            for (int k = 0; k < MAX_SIG_BYTES - 1; k++) begin
                r_window[k] <= '0;
            end
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_seen     <= '0;
                r_reported <= 1'b0;
                for (int k = 0; k < MAX_SIG_BYTES - 1; k++) begin
                    r_window[k] <= '0;
                end
            end else if (!r_reported) begin
                r_seen     <= n_seen;
                r_reported <= match;
                for (int k = 0; k < MAX_SIG_BYTES - 1; k++) begin
                    r_window[k] <= age_byte[k];
                end
            end
        end
    end

endmodule

// File: hdl/wbps_result.sv
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scan_unit_assert.svh"
// ----------------------------------------------------------------------------
// wbps_result
// holding stage for a decided result and the output register with the address add
// ----------------------------------------------------------------------------
module wbps_result (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wbps_pkg::t_hit         i_hit,
    input  wbps_pkg::t_addr_cfg    i_addr_cfg,
    output logic                   o_in_ready,
    wbps_out_if.source             o_out
);
    import wbps_pkg::*;

    logic              r_a_valid;
    logic              r_a_found;
    logic [CNT_W-1:0]  r_a_start;
    logic              r_o_valid;
    logic              r_o_found;
    logic [ADDR_W-1:0] r_o_addr;
    logic              a_move;

    assign a_move     = r_a_valid && (!r_o_valid || o_out.ready);
    assign o_in_ready = !r_a_valid || a_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_hit.valid) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hit.valid) begin
            r_a_found <= i_hit.found;
            r_a_start <= i_hit.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_move) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_o_found <= r_a_found;
            r_o_addr  <= r_a_found
                ? i_addr_cfg.base_address + ADDR_W'(r_a_start)
                  + ADDR_W'(i_addr_cfg.added_offset)
                : '0;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.found         = r_o_found;
    assign o_out.match_address = r_o_addr;

    `WBPS_ASSERT_SAME(a_not_found_zero, r_o_valid && !r_o_found, r_o_addr == '0)
    `WBPS_ASSERT_NEXT(a_stage_holds, r_a_valid && !a_move, r_a_valid)
    `WBPS_ASSERT_SAME(a_hit_only_when_room, i_hit.valid, o_in_ready)

endmodule
